>>> hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the converter core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/bspb_pkg.sv
// Shared types and constants of the B-spline to Bezier converter.
package bspb_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    // Quotient bits resolved per divider stage.
    localparam int DIV_STEP = 8;
    localparam int NUM_AXES = 3;

    localparam logic KIND_JUNCTION = 1'b0;
    localparam logic KIND_INNER    = 1'b1;

    // Which weighted average a lane forms: (2a+b)/3, (a+2b)/3 or (a+4b+d)/6.
    typedef enum logic [1:0] {
        JOB_INNER_A,
        JOB_INNER_B,
        JOB_JUNCTION
    } t_job;

    typedef struct packed {
        logic valid;
        logic kind;
        logic last;
    } t_tag;

endpackage

>>> hw/rtl/bspb_in_if.sv
// Control point channel: valid/ready handshake with the point payload.
interface bspb_in_if #(
    parameter int COORD_WIDTH = bspb_pkg::COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic                          curve_start;

    modport source (output valid, point_x, point_y, point_z, curve_start, input ready);
    modport sink   (input valid, point_x, point_y, point_z, curve_start, output ready);
endinterface

>>> hw/rtl/bspb_out_if.sv
// Bezier point channel: valid/ready handshake with the result payload.
interface bspb_out_if #(
    parameter int COORD_WIDTH = bspb_pkg::COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] bez_x;
    logic signed [COORD_WIDTH-1:0] bez_y;
    logic signed [COORD_WIDTH-1:0] bez_z;
    logic                          point_kind;
    logic                          last_of_run;

    modport source (output valid, bez_x, bez_y, bez_z, point_kind, last_of_run, input ready);
    modport sink   (input valid, bez_x, bez_y, bez_z, point_kind, last_of_run, output ready);
endinterface

>>> hw/rtl/bspline_to_bezier_points_core.sv
// Top level of the uniform cubic B-spline to Bezier control point converter.
//
//  Channel   Dir  Payload                                    Transaction
//  i_pt      in   point_x/y/z (Q16.16), curve_start          one de Boor point
//  o_bez     out  bez_x/y/z (Q16.16), point_kind, last_of_run one Bezier point
//
//  A point that yields three results, or a single junction, holds the input until its last
//  job issues; one that yields nothing does not hold it. The single issue slot into the
//  lanes sets this. From transaction to first result lie the issue registers, the sum
//  register, the divide-by-three stages and the output register.
//  Synchronous active-low reset clears the point count, the sequencer and all valids.
//  A held result stalls the whole lane pipe; the sequencer still takes a point when idle.
module bspline_to_bezier_points_core #(
    parameter int COORD_WIDTH = bspb_pkg::COORD_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bspb_in_if.sink    i_pt,
    bspb_out_if.source o_bez
);
    import bspb_pkg::*;
    `include "assert_macros.svh"

    localparam int NST = (COORD_WIDTH + 3 + DIV_STEP - 1) / DIV_STEP;
    localparam int LAT = NST + 1;

    localparam logic [1:0] SEEN_TWO  = 2'd2;
    localparam logic [1:0] SEEN_FULL = 2'd3;

    // Window of the current curve.
    logic signed [COORD_WIDTH-1:0] r_older [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] r_newer [NUM_AXES];
    logic        [1:0]             r_seen;

    // Sequencer: operands of the point being issued and its next job.
    logic                          r_busy;
    t_job                          r_job;
    logic signed [COORD_WIDTH-1:0] r_ja [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] r_jb [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] r_jp [NUM_AXES];

    logic                          acc, en, iss;
    logic        [1:0]             seen_eff;
    logic signed [COORD_WIDTH-1:0] p_in [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] a_eff [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] b_eff [NUM_AXES];

    t_tag                          n_tag;
    t_tag                          r_tag [LAT];
    logic        [COORD_WIDTH-1:0] lane_q [NUM_AXES];

    assign p_in[0] = i_pt.point_x;
    assign p_in[1] = i_pt.point_y;
    assign p_in[2] = i_pt.point_z;

    assign acc = i_pt.valid && i_pt.ready;
    assign iss = r_busy && en;

    // Take a new point when idle or while the last job of the current one issues.
    assign i_pt.ready = !r_busy || (en && r_job == JOB_JUNCTION);

    // A curve start empties the window before the point joins it.
    assign seen_eff = i_pt.curve_start ? 2'd0 : r_seen;
    for (genvar k = 0; k < NUM_AXES; k++) begin : g_win
        assign a_eff[k] = i_pt.curve_start ? '0 : r_older[k];
        assign b_eff[k] = i_pt.curve_start ? '0 : r_newer[k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_busy <= 1'b0;
            r_job  <= JOB_INNER_A;
        end else if (acc) begin
            r_seen <= (seen_eff == SEEN_FULL) ? SEEN_FULL : seen_eff + 2'd1;
            if (seen_eff == SEEN_FULL) begin
                r_busy <= 1'b1;
                r_job  <= JOB_INNER_A;
            end else if (seen_eff == SEEN_TWO) begin
                r_busy <= 1'b1;
                r_job  <= JOB_JUNCTION;
            end else begin
                r_busy <= 1'b0;
            end
        end else if (iss) begin
            case (r_job)
                JOB_INNER_A: r_job  <= JOB_INNER_B;
                JOB_INNER_B: r_job  <= JOB_JUNCTION;
                default:     r_busy <= 1'b0;
            endcase
        end
    end

    // Shift the window and snapshot the operands on every transaction.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_older[k] <= b_eff[k];
                r_newer[k] <= p_in[k];
                r_ja[k]    <= a_eff[k];
                r_jb[k]    <= b_eff[k];
                r_jp[k]    <= p_in[k];
            end
        end
    end

    // Tag travels alongside the lanes: junctions close the run.
    always_comb begin
        n_tag.valid = iss;
        n_tag.kind  = (r_job == JOB_JUNCTION) ? KIND_JUNCTION : KIND_INNER;
        n_tag.last  = (r_job == JOB_JUNCTION);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LAT; s++) begin
                r_tag[s] <= '0;
            end
        end else if (en) begin
            r_tag[0] <= n_tag;
            for (int s = 1; s < LAT; s++) begin
                r_tag[s] <= r_tag[s-1];
            end
        end
    end

    for (genvar k = 0; k < NUM_AXES; k++) begin : g_lane
        bspb_lane #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_job (r_job),
            .i_a   (r_ja[k]),
            .i_b   (r_jb[k]),
            .i_p   (r_jp[k]),
            .o_q   (lane_q[k])
        );
    end

    bspb_merge #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_tag[LAT-1]),
        .i_q     (lane_q),
        .o_en    (en),
        .o_bez   (o_bez)
    );

    `ASSERT_NEXT(a_run3, acc && seen_eff == SEEN_FULL, r_busy && r_job == JOB_INNER_A, "no run")
    `ASSERT_NEXT(a_jct, acc && seen_eff == SEEN_TWO, r_busy && r_job == JOB_JUNCTION, "junction")
    `ASSERT_NEXT(a_none, acc && seen_eff < SEEN_TWO, !r_busy, "result from opening point")
    `ASSERT_NEXT(a_hold, !en, $stable(r_tag[LAT-1]), "stalled tag moved")

endmodule

>>> hw/rtl/bspb_lane.sv
// One coordinate lane: weighted sum, then a pipelined divide by six with rounding.
module bspb_lane #(
    parameter int COORD_WIDTH = bspb_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  bspb_pkg::t_job                i_job,
    input  logic signed [COORD_WIDTH-1:0] i_a,
    input  logic signed [COORD_WIDTH-1:0] i_b,
    input  logic signed [COORD_WIDTH-1:0] i_p,
    output logic        [COORD_WIDTH-1:0] o_q
);
    import bspb_pkg::*;

    localparam int SW  = COORD_WIDTH + 4;
    localparam int QW  = COORD_WIDTH + 3;
    localparam int NST = (QW + DIV_STEP - 1) / DIV_STEP;
    localparam int QP  = NST * DIV_STEP;
    localparam int IW  = $clog2(QP);
    // Rounding half plus an offset of 6*2^W keeps the dividend positive.
    localparam logic [SW-1:0] BIAS = SW'(3) | (SW'(6) << COORD_WIDTH);

    logic signed [SW-1:0] sa, sb, sp, w_sum;
    logic        [SW-1:0] n_sum, r_sum;
    logic        [QP-1:0] r_val [NST];
    logic        [1:0]    r_rem [NST];

    assign sa = SW'(i_a);
    assign sb = SW'(i_b);
    assign sp = SW'(i_p);

    // Thirds are formed as sixths of doubled weights; the even sum never ties.
    always_comb begin
        case (i_job)
            JOB_INNER_A:  w_sum = (sa <<< 2) + (sb <<< 1);
            JOB_INNER_B:  w_sum = (sa <<< 1) + (sb <<< 2);
            JOB_JUNCTION: w_sum = sa + (sb <<< 2) + sp;
            default:      w_sum = '0;
        endcase
    end

    assign n_sum = w_sum + BIAS;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    // Halve, then long division by three, DIV_STEP quotient bits per stage.
    for (genvar s = 0; s < NST; s++) begin : g_div
        localparam int TOP = QP - 1 - s * DIV_STEP;
        logic [QP-1:0] v_in, v_out;
        logic [1:0]    rm_in, rm_out;

        if (s == 0) begin : g_first
            assign v_in  = QP'(r_sum[SW-1:1]);
            assign rm_in = '0;
        end else begin : g_next
            assign v_in  = r_val[s-1];
            assign rm_in = r_rem[s-1];
        end

        always_comb begin : p_step
            logic [2:0] t;
            v_out  = v_in;
            rm_out = rm_in;
            t      = '0;
            for (int j = 0; j < DIV_STEP; j++) begin
                t = {rm_out, v_in[IW'(TOP - j)]};
                if (t >= 3'd3) begin
                    v_out[IW'(TOP - j)] = 1'b1;
                    rm_out              = 2'(t - 3'd3);
                end else begin
                    v_out[IW'(TOP - j)] = 1'b0;
                    rm_out              = t[1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_val[s] <= v_out;
                r_rem[s] <= rm_out;
            end
        end
    end

    // Low bits drop the 2^W offset.
    assign o_q = r_val[NST-1][COORD_WIDTH-1:0];

endmodule

>>> hw/rtl/bspb_merge.sv
// Output register: joins the lane results with their tag and drives the result channel.
module bspb_merge #(
    parameter int COORD_WIDTH = bspb_pkg::COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bspb_pkg::t_tag         i_tag,
    input  logic [COORD_WIDTH-1:0] i_q [bspb_pkg::NUM_AXES],
    output logic                   o_en,
    bspb_out_if.source             o_bez
);
    import bspb_pkg::*;

    logic                          r_valid;
    logic signed [COORD_WIDTH-1:0] r_x, r_y, r_z;
    logic                          r_kind, r_last;

    // Advance the pipe whenever the output slot is free or being emptied.
    assign o_en = !r_valid || o_bez.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_x    <= i_q[0];
            r_y    <= i_q[1];
            r_z    <= i_q[2];
            r_kind <= i_tag.kind;
            r_last <= i_tag.last;
        end
    end

    assign o_bez.valid       = r_valid;
    assign o_bez.bez_x       = r_x;
    assign o_bez.bez_y       = r_y;
    assign o_bez.bez_z       = r_z;
    assign o_bez.point_kind  = r_kind;
    assign o_bez.last_of_run = r_last;

endmodule
